### rtl/core/msq_pkg.sv
// Shared types, constants and tables of the MIDI step sequencer.
`default_nettype none

package msq_pkg;

  localparam int unsigned STEP_COUNT_DEF = 16;
  localparam int unsigned CMD_Q_DEPTH    = 2;

  localparam int unsigned MODE_W  = 3;
  localparam int unsigned NOTE_W  = 7;
  localparam int unsigned VEL_W   = 7;
  localparam int unsigned STEP_W  = 4;
  localparam int unsigned CNT_W   = 26;
  localparam int unsigned TDATA_W = 24;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = CNT_W;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_STEP_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_STEP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_STEP   = 2'd2;

  localparam logic [CNT_W-1:0]  STEP_PERIOD_RST = 26'd500000;
  localparam logic [STEP_W-1:0] FIRST_STEP_RST  = 4'd0;
  localparam logic [STEP_W-1:0] LAST_STEP_RST   = 4'd15;
  localparam logic [VEL_W-1:0]  VEL_RST         = 7'd127;
  localparam logic [CNT_W-1:0]  CNT_MAX         = '1;

  // Input mode codes
  localparam logic [MODE_W-1:0] MODE_TICK    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_NOTE    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_EDIT    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_TOGGLE  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_RECORD  = 3'd4;

  typedef enum logic [2:0] {
    CMD_TICK,
    CMD_NOTE,
    CMD_EDIT,
    CMD_TOGGLE,
    CMD_RECORD
  } cmd_kind_e;

  typedef enum logic {
    EVT_NOTE_ON  = 1'b0,
    EVT_NOTE_OFF = 1'b1
  } evt_kind_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  vel;
    logic [STEP_W-1:0] idx;
    logic              active;
  } cmd_t;

  typedef struct packed {
    evt_kind_e         kind;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  vel;
    logic [STEP_W-1:0] step;
    logic              last;
  } evt_t;

  // Power-up pattern, repeated every sixteen steps
  function automatic logic [NOTE_W-1:0] preset_note(input logic [STEP_W-1:0] idx);
    logic [NOTE_W-1:0] n;
    case (idx)
      4'd0:    n = 7'd74;
      4'd1:    n = 7'd78;
      4'd2:    n = 7'd81;
      4'd3:    n = 7'd86;
      4'd4:    n = 7'd90;
      4'd5:    n = 7'd93;
      4'd6:    n = 7'd98;
      4'd7:    n = 7'd102;
      4'd8:    n = 7'd57;
      4'd9:    n = 7'd61;
      4'd10:   n = 7'd66;
      4'd11:   n = 7'd69;
      4'd12:   n = 7'd73;
      4'd13:   n = 7'd78;
      4'd14:   n = 7'd81;
      default: n = 7'd85;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

### rtl/core/msq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module msq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### rtl/core/msq_front.sv
// Front end: accepts input items, classifies them and queues commands.
`default_nettype none

module msq_front
  import msq_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [TDATA_W-1:0] s_axis_tdata,
  input  wire logic [MODE_W-1:0]  s_axis_tuser,
  output logic                    cmd_valid_o,
  output cmd_t                    cmd_o,
  input  wire logic               cmd_pop_i
);

  localparam int unsigned PW = (CMD_Q_DEPTH > 1) ? $clog2(CMD_Q_DEPTH) : 1;
  localparam int unsigned CW = $clog2(CMD_Q_DEPTH + 1);

  cmd_t           q_mem_q [CMD_Q_DEPTH];
  logic [PW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]  count_q, count_d;
  cmd_t           cmd_in;
  logic           keep;
  logic           push;
  logic           pop;

  // Classify the item; drop codes that do nothing and zero-velocity notes
  always_comb begin
    cmd_in.note   = s_axis_tdata[NOTE_W-1:0];
    cmd_in.vel    = s_axis_tdata[NOTE_W+VEL_W-1:NOTE_W];
    cmd_in.idx    = s_axis_tdata[NOTE_W+VEL_W+STEP_W-1:NOTE_W+VEL_W];
    cmd_in.active = s_axis_tdata[NOTE_W+VEL_W+STEP_W];
    cmd_in.kind   = CMD_TICK;
    keep          = 1'b1;
    case (s_axis_tuser)
      MODE_TICK:   cmd_in.kind = CMD_TICK;
      MODE_NOTE: begin
        cmd_in.kind = CMD_NOTE;
        keep        = (cmd_in.vel != '0);
      end
      MODE_EDIT:   cmd_in.kind = CMD_EDIT;
      MODE_TOGGLE: cmd_in.kind = CMD_TOGGLE;
      MODE_RECORD: cmd_in.kind = CMD_RECORD;
      default:     keep = 1'b0;
    endcase
  end

  assign s_axis_tready = (32'(count_q) != CMD_Q_DEPTH);
  assign push          = s_axis_tvalid && s_axis_tready && keep;
  assign cmd_valid_o   = (count_q != '0);
  assign cmd_o         = q_mem_q[rd_ptr_q];
  assign pop           = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (32'(wr_ptr_q) == CMD_Q_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (32'(rd_ptr_q) == CMD_Q_DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

### rtl/core/msq_back.sv
// Back end: pattern store, play/record state, timing counters and event output.
`default_nettype none

module msq_back
  import msq_pkg::*;
#(
  parameter int unsigned STEP_COUNT = STEP_COUNT_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cmd_valid_i,
  input  wire cmd_t                  cmd_i,
  output logic                       cmd_pop_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                       evt_valid_o,
  input  wire logic                  evt_ready_i,
  output evt_t                       evt_o
);

  localparam int unsigned IW   = $clog2(STEP_COUNT);
  localparam int unsigned NV_W = NOTE_W + VEL_W;
  localparam logic [IW-1:0] PREV_RST = (STEP_COUNT > 16) ? IW'(15) : IW'(STEP_COUNT - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EMIT,
    S_REC_OFF
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  period_q, period_d;
  logic [STEP_W-1:0] first_q, first_d;
  logic [STEP_W-1:0] last_q, last_d;
  logic [IW-1:0]     cur_q, cur_d;
  logic [IW-1:0]     prev_q, prev_d;
  logic              play_q, play_d;
  logic              rec_q, rec_d;
  logic [CNT_W-1:0]  tsp_q, tsp_d;
  logic [CNT_W-1:0]  tso_q, tso_d;
  logic [STEP_COUNT-1:0] nv_valid_q, nv_valid_d;
  logic [STEP_COUNT-1:0] en_valid_q, en_valid_d;
  logic              nv_vld_rd_q, en_vld_rd_q;
  logic [IW-1:0]     rd_addr_q;

  // Pending emission descriptor
  evt_kind_e         ekind_q, ekind_d;
  logic [IW-1:0]     estep_q, estep_d;
  logic              elast_q, elast_d;
  logic              need_en_q, need_en_d;
  logic              sweep_q, sweep_d;
  logic              edit_q, edit_d;
  logic [NOTE_W-1:0] hold_note_q, hold_note_d;
  logic [VEL_W-1:0]  hold_vel_q, hold_vel_d;
  logic              hold_act_q, hold_act_d;

  logic              out_vld_q;
  evt_t              out_q;
  logic              emit;
  evt_t              emit_evt;
  logic              slot_free;

  logic              rd_en;
  logic [IW-1:0]     rd_addr;
  logic              nv_we;
  logic [IW-1:0]     nv_waddr;
  logic [NV_W-1:0]   nv_wdata;
  logic              en_we;
  logic              en_wdata;
  logic [NV_W-1:0]   nv_rdata;
  logic [0:0]        en_rdata;
  logic [NOTE_W-1:0] rd_note;
  logic [VEL_W-1:0]  rd_vel;
  logic              rd_en_flag;
  logic [CNT_W-1:0]  tsp_n, tso_n;
  logic [IW-1:0]     eidx;

  function automatic logic [IW-1:0] clamp_idx(input logic [STEP_W-1:0] v);
    logic [IW-1:0] r;
    if (32'(v) < STEP_COUNT) begin
      r = IW'(v);
    end else begin
      r = IW'(STEP_COUNT - 1);
    end
    return r;
  endfunction

  function automatic logic [IW-1:0] next_step(input logic [IW-1:0] cur,
                                              input logic [STEP_W-1:0] first,
                                              input logic [STEP_W-1:0] last);
    logic [IW:0]   nxt;
    logic [IW-1:0] r;
    nxt = {1'b0, cur} + 1'b1;
    if (32'(nxt) > 32'(last) || 32'(nxt) >= STEP_COUNT) begin
      r = clamp_idx(first);
    end else begin
      r = nxt[IW-1:0];
    end
    return r;
  endfunction

  msq_ram #(
    .WIDTH(NV_W),
    .DEPTH(STEP_COUNT)
  ) u_nv_ram (
    .clk_i   (clk_i),
    .we_i    (nv_we),
    .waddr_i (nv_waddr),
    .wdata_i (nv_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (nv_rdata)
  );

  msq_ram #(
    .WIDTH(1),
    .DEPTH(STEP_COUNT)
  ) u_en_ram (
    .clk_i   (clk_i),
    .we_i    (en_we),
    .waddr_i (nv_waddr),
    .wdata_i (en_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (en_rdata)
  );

  // Never-written entries read as the power-up pattern
  assign rd_note    = nv_vld_rd_q ? nv_rdata[NOTE_W-1:0] : preset_note(STEP_W'(rd_addr_q));
  assign rd_vel     = nv_vld_rd_q ? nv_rdata[NV_W-1:NOTE_W] : VEL_RST;
  assign rd_en_flag = en_vld_rd_q ? en_rdata[0] : 1'b1;

  assign slot_free = !out_vld_q || evt_ready_i;
  assign tsp_n     = (tsp_q != CNT_MAX) ? tsp_q + 1'b1 : tsp_q;
  assign tso_n     = (tso_q != CNT_MAX) ? tso_q + 1'b1 : tso_q;
  assign eidx      = clamp_idx(cmd_i.idx);

  always_comb begin
    state_d     = state_q;
    period_d    = period_q;
    first_d     = first_q;
    last_d      = last_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    play_d      = play_q;
    rec_d       = rec_q;
    tsp_d       = tsp_q;
    tso_d       = tso_q;
    nv_valid_d  = nv_valid_q;
    en_valid_d  = en_valid_q;
    ekind_d     = ekind_q;
    estep_d     = estep_q;
    elast_d     = elast_q;
    need_en_d   = need_en_q;
    sweep_d     = sweep_q;
    edit_d      = edit_q;
    hold_note_d = hold_note_q;
    hold_vel_d  = hold_vel_q;
    hold_act_d  = hold_act_q;
    cmd_pop_o   = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = '0;
    nv_we       = 1'b0;
    en_we       = 1'b0;
    nv_waddr    = cur_q;
    nv_wdata    = {cmd_i.vel, cmd_i.note};
    en_wdata    = hold_act_q;
    emit        = 1'b0;
    emit_evt    = '{kind: EVT_NOTE_OFF, note: rd_note, vel: '0,
                    step: STEP_W'(estep_q), last: elast_q};

    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_STEP_PERIOD: period_d = cfg_data_i;
        REG_FIRST_STEP:  first_d  = cfg_data_i[STEP_W-1:0];
        REG_LAST_STEP:   last_d   = cfg_data_i[STEP_W-1:0];
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && slot_free) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.kind)
            CMD_TICK: begin
              tsp_d = tsp_n;
              tso_d = tso_n;
              if (play_q && tsp_n > period_q) begin
                tsp_d     = '0;
                rd_en     = 1'b1;
                rd_addr   = cur_q;
                ekind_d   = EVT_NOTE_ON;
                estep_d   = cur_q;
                elast_d   = 1'b1;
                need_en_d = 1'b1;
                prev_d    = cur_q;
                cur_d     = next_step(cur_q, first_q, last_q);
                state_d   = S_EMIT;
              end else if (play_q && tsp_n > (period_q >> 1) && tso_n > period_q) begin
                tso_d     = '0;
                rd_en     = 1'b1;
                rd_addr   = prev_q;
                ekind_d   = EVT_NOTE_OFF;
                estep_d   = prev_q;
                elast_d   = 1'b1;
                need_en_d = 1'b0;
                state_d   = S_EMIT;
              end
            end
            CMD_NOTE: begin
              if (rec_q) begin
                nv_we               = 1'b1;
                nv_waddr            = cur_q;
                nv_valid_d[cur_q]   = 1'b1;
                emit                = 1'b1;
                emit_evt            = '{kind: EVT_NOTE_ON, note: cmd_i.note, vel: cmd_i.vel,
                                        step: STEP_W'(cur_q), last: 1'b0};
                hold_note_d         = cmd_i.note;
                estep_d             = cur_q;
                prev_d              = cur_q;
                cur_d               = next_step(cur_q, first_q, last_q);
                state_d             = S_REC_OFF;
              end
            end
            CMD_EDIT: begin
              rd_en       = 1'b1;
              rd_addr     = eidx;
              ekind_d     = EVT_NOTE_OFF;
              estep_d     = eidx;
              elast_d     = 1'b1;
              need_en_d   = 1'b0;
              edit_d      = 1'b1;
              hold_note_d = cmd_i.note;
              hold_vel_d  = cmd_i.vel;
              hold_act_d  = cmd_i.active;
              state_d     = S_EMIT;
            end
            CMD_TOGGLE: begin
              play_d = !play_q;
              rec_d  = 1'b0;
              if (play_q) begin
                // Stop: sweep note-offs over the whole pattern
                rd_en     = 1'b1;
                rd_addr   = '0;
                ekind_d   = EVT_NOTE_OFF;
                estep_d   = '0;
                elast_d   = 1'b0;
                need_en_d = 1'b0;
                sweep_d   = 1'b1;
                state_d   = S_EMIT;
              end
            end
            CMD_RECORD: begin
              play_d = 1'b0;
              rec_d  = 1'b1;
              cur_d  = '0;
              prev_d = clamp_idx(last_q);
            end
            default: ;
          endcase
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          emit              = !(need_en_q && !rd_en_flag);
          emit_evt.kind     = ekind_q;
          emit_evt.note     = rd_note;
          emit_evt.vel      = (ekind_q == EVT_NOTE_ON) ? rd_vel : '0;
          if (edit_q) begin
            nv_we               = 1'b1;
            en_we               = 1'b1;
            nv_waddr            = estep_q;
            nv_wdata            = {hold_vel_q, hold_note_q};
            en_wdata            = hold_act_q;
            nv_valid_d[estep_q] = 1'b1;
            en_valid_d[estep_q] = 1'b1;
            edit_d              = 1'b0;
          end
          if (sweep_q && !elast_q) begin
            rd_en   = 1'b1;
            rd_addr = estep_q + 1'b1;
            estep_d = estep_q + 1'b1;
            elast_d = (32'(estep_q) + 1 == STEP_COUNT - 1);
          end else begin
            sweep_d = 1'b0;
            state_d = S_IDLE;
          end
        end
      end
      S_REC_OFF: begin
        if (slot_free) begin
          emit     = 1'b1;
          emit_evt = '{kind: EVT_NOTE_OFF, note: hold_note_q, vel: '0,
                       step: STEP_W'(estep_q), last: 1'b1};
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      period_q   <= STEP_PERIOD_RST;
      first_q    <= FIRST_STEP_RST;
      last_q     <= LAST_STEP_RST;
      cur_q      <= '0;
      prev_q     <= PREV_RST;
      play_q     <= 1'b1;
      rec_q      <= 1'b0;
      tsp_q      <= '0;
      tso_q      <= '0;
      nv_valid_q <= '0;
      en_valid_q <= '0;
      need_en_q  <= 1'b0;
      sweep_q    <= 1'b0;
      edit_q     <= 1'b0;
      elast_q    <= 1'b0;
      ekind_q    <= EVT_NOTE_OFF;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      period_q   <= period_d;
      first_q    <= first_d;
      last_q     <= last_d;
      cur_q      <= cur_d;
      prev_q     <= prev_d;
      play_q     <= play_d;
      rec_q      <= rec_d;
      tsp_q      <= tsp_d;
      tso_q      <= tso_d;
      nv_valid_q <= nv_valid_d;
      en_valid_q <= en_valid_d;
      need_en_q  <= need_en_d;
      sweep_q    <= sweep_d;
      edit_q     <= edit_d;
      elast_q    <= elast_d;
      ekind_q    <= ekind_d;
      if (emit) begin
        out_vld_q <= 1'b1;
      end else if (evt_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    estep_q     <= estep_d;
    hold_note_q <= hold_note_d;
    hold_vel_q  <= hold_vel_d;
    hold_act_q  <= hold_act_d;
    if (rd_en) begin
      rd_addr_q   <= rd_addr;
      nv_vld_rd_q <= nv_valid_q[rd_addr];
      en_vld_rd_q <= en_valid_q[rd_addr];
    end
    if (emit) begin
      out_q <= emit_evt;
    end
  end

  assign evt_valid_o = out_vld_q;
  assign evt_o       = out_q;

endmodule

`default_nettype wire

### rtl/core/midi_step_sequencer.sv
// MIDI step sequencer: a step pattern played from ticks, with record, edit and stop.
//
// Input stream (s_axis): one item per transaction; tuser carries the mode (tick,
// received note-on, edit step, toggle play, enter record). A two-entry command
// queue takes an item in every cycle while it has room.
// Output stream (m_axis): note-on/note-off events; tuser is the event kind and
// tlast marks the final event caused by one input item.
// Event path: an item is written to the command queue; the back end pops it when
// idle and the output register is free, reads the pattern RAM for a tick or edit
// event, then loads the event into the output register. An item with no event is
// popped with no output; a recorded note emits its note-on, then its note-off; a stop
// sends STEP_COUNT note-offs, one note-off per cycle while the output register is free.
// Reset: pattern returns to its power-up notes at full velocity with every step
// enabled, playback running from step 0, period 500000 ticks.
// Receiver stall: the output register holds its event, the back end waits, and
// the command queue fills before s_axis_tready drops.
// Configuration: cfg_we_i writes register cfg_idx_i (0 step period, 1 first
// step, 2 last step) at the clock edge; write only while idle.
`default_nettype none

module midi_step_sequencer
  import msq_pkg::*;
#(
  parameter int unsigned STEP_COUNT = STEP_COUNT_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // note_value[6:0], note_velocity[13:7], edit_index[17:14], edit_active[18], zero
  input  wire logic [TDATA_W-1:0]    s_axis_tdata,
  // mode[2:0]
  input  wire logic [MODE_W-1:0]     s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // out_note[6:0], out_velocity[13:7], out_step[17:14], zero
  output logic      [TDATA_W-1:0]    m_axis_tdata,
  // event_kind[0]
  output logic                       m_axis_tuser,
  output logic                       m_axis_tlast,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;
  evt_t evt;

  msq_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_pop_i     (cmd_pop)
  );

  msq_back #(
    .STEP_COUNT(STEP_COUNT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .evt_valid_o (m_axis_tvalid),
    .evt_ready_i (m_axis_tready),
    .evt_o       (evt)
  );

  assign m_axis_tdata = {(TDATA_W - NOTE_W - VEL_W - STEP_W)'(0), evt.step, evt.vel, evt.note};
  assign m_axis_tuser = evt.kind;
  assign m_axis_tlast = evt.last;

endmodule

`default_nettype wire

### tb/msq_event_checker.sv
// Event checker for the MIDI step sequencer: tracks the pattern state and compares events.
module msq_event_checker
  import msq_pkg::*;
#(
  parameter int unsigned STEPS = STEP_COUNT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [TDATA_W-1:0]    s_axis_tdata,
  input  logic [MODE_W-1:0]     s_axis_tuser,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [TDATA_W-1:0]    m_axis_tdata,
  input  logic                  m_axis_tuser,
  input  logic                  m_axis_tlast,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_count,
  output int                    pending,
  output int                    events_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned REPORT_LIMIT = 10;
  // Power-up notes, step 0 in the lowest bits
  localparam logic [16*NOTE_W-1:0] POWERUP_NOTES = {
    7'd85, 7'd81, 7'd78, 7'd73, 7'd69, 7'd66, 7'd61, 7'd57,
    7'd102, 7'd98, 7'd93, 7'd90, 7'd86, 7'd81, 7'd78, 7'd74
  };

  logic [NOTE_W-1:0] pat_note [STEPS];
  logic [VEL_W-1:0]  pat_vel  [STEPS];
  logic              pat_on   [STEPS];
  logic [STEP_W-1:0] cur_step;
  logic [STEP_W-1:0] prev_step;
  logic              playing;
  logic              recording;
  logic [CNT_W-1:0]  since_on;
  logic [CNT_W-1:0]  since_off;
  logic [CNT_W-1:0]  period;
  logic [STEP_W-1:0] wrap_to;
  logic [STEP_W-1:0] wrap_after;

  evt_t due_events[$];

  task automatic clear_model();
    for (int i = 0; i < STEPS; i++) begin
      pat_note[i] = POWERUP_NOTES[(i % 16) * NOTE_W +: NOTE_W];
      pat_vel[i]  = VEL_RST;
      pat_on[i]   = 1'b1;
    end
    cur_step   = '0;
    prev_step  = STEP_W'(STEPS - 1);
    playing    = 1'b1;
    recording  = 1'b0;
    since_on   = '0;
    since_off  = '0;
    period     = STEP_PERIOD_RST;
    wrap_to    = FIRST_STEP_RST;
    wrap_after = LAST_STEP_RST;
  endtask

  task automatic add_event(input evt_kind_e kind, input logic [NOTE_W-1:0] note,
                           input logic [VEL_W-1:0] vel, input logic [STEP_W-1:0] step);
    evt_t e;
    e.kind = kind;
    e.note = note;
    e.vel  = vel;
    e.step = step;
    e.last = 1'b0;
    due_events.push_back(e);
  endtask

  task automatic advance_step();
    logic [STEP_W:0] nxt;
    nxt = {1'b0, cur_step} + 1'b1;
    prev_step = cur_step;
    if (nxt > {1'b0, wrap_after} || nxt >= STEPS) begin
      nxt = (wrap_to < STEPS) ? {1'b0, wrap_to} : (STEP_W + 1)'(STEPS - 1);
    end
    cur_step = nxt[STEP_W-1:0];
  endtask

  task automatic play_item(input logic [MODE_W-1:0] mode, input logic [TDATA_W-1:0] data);
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  vel;
    logic [STEP_W-1:0] idx;
    logic              act;
    int                first_new;
    evt_t              e;
    note = data[6:0];
    vel  = data[13:7];
    idx  = (data[17:14] < STEPS) ? data[17:14] : STEP_W'(STEPS - 1);
    act  = data[18];
    first_new = due_events.size();
    case (mode)
      MODE_TICK: begin
        if (since_on != CNT_MAX) since_on = since_on + 1'b1;
        if (since_off != CNT_MAX) since_off = since_off + 1'b1;
        if (playing && since_on > period) begin
          since_on = '0;
          if (pat_on[cur_step]) begin
            add_event(EVT_NOTE_ON, pat_note[cur_step], pat_vel[cur_step], cur_step);
          end
          advance_step();
        end else if (playing && since_on > (period >> 1) && since_off > period) begin
          // release the step played last, even if it has been disabled since
          since_off = '0;
          add_event(EVT_NOTE_OFF, pat_note[prev_step], '0, prev_step);
        end
      end
      MODE_NOTE: begin
        if (recording && vel != '0) begin
          pat_note[cur_step] = note;
          pat_vel[cur_step]  = vel;
          add_event(EVT_NOTE_ON, note, vel, cur_step);
          add_event(EVT_NOTE_OFF, note, '0, cur_step);
          advance_step();
        end
      end
      MODE_EDIT: begin
        add_event(EVT_NOTE_OFF, pat_note[idx], '0, idx);
        pat_note[idx] = note;
        pat_vel[idx]  = vel;
        pat_on[idx]   = act;
      end
      MODE_TOGGLE: begin
        playing   = !playing;
        recording = 1'b0;
        if (!playing) begin
          for (int i = 0; i < STEPS; i++) add_event(EVT_NOTE_OFF, pat_note[i], '0, STEP_W'(i));
        end
      end
      MODE_RECORD: begin
        playing   = 1'b0;
        recording = 1'b1;
        cur_step  = '0;
        prev_step = (wrap_after < STEPS) ? wrap_after : STEP_W'(STEPS - 1);
      end
      default: ;
    endcase
    if (due_events.size() > first_new) begin
      e = due_events.pop_back();
      e.last = 1'b1;
      due_events.push_back(e);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    evt_t want;
    evt_t got;
    if (!rst_ni) begin
      clear_model();
      due_events.delete();
      fail_count  = 0;
      events_seen = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_STEP_PERIOD: period = cfg_data_i[CNT_W-1:0];
          REG_FIRST_STEP:  wrap_to = cfg_data_i[STEP_W-1:0];
          REG_LAST_STEP:   wrap_after = cfg_data_i[STEP_W-1:0];
          default: ;
        endcase
      end
      // compare before predicting: an item accepted now cannot have an event out yet
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind = evt_kind_e'(m_axis_tuser);
        got.note = m_axis_tdata[6:0];
        got.vel  = m_axis_tdata[13:7];
        got.step = m_axis_tdata[17:14];
        got.last = m_axis_tlast;
        if (due_events.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT) begin
            $display("[%0t] event %0d arrived with none due: kind %0d note %0d vel %0d step %0d last %0d",
                     $time, events_seen, got.kind, got.note, got.vel, got.step, got.last);
          end
        end else begin
          want = due_events.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
              $display("[%0t] event %0d differs: expected kind %0d note %0d vel %0d step %0d last %0d",
                       $time, events_seen, want.kind, want.note, want.vel, want.step, want.last);
              $display("          got kind %0d note %0d vel %0d step %0d last %0d",
                       got.kind, got.note, got.vel, got.step, got.last);
            end
          end
        end
        events_seen++;
      end
      if (s_axis_tvalid && s_axis_tready) play_item(s_axis_tuser, s_axis_tdata);
    end
    pending = due_events.size();
  end

endmodule

### tb/midi_step_sequencer_tb.sv
// Testbench top for the MIDI step sequencer: stimulus, output backpressure and verdict.
module midi_step_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import msq_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 48;
  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [TDATA_W-1:0]    s_axis_tdata;
  logic [MODE_W-1:0]     s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [TDATA_W-1:0]    m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int fail_count;
  int pending;
  int events_seen;
  int accepted_items = 0;
  int timing_settings = 0;
  bit gaps_on = 1'b1;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  midi_step_sequencer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  msq_event_checker event_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .fail_count    (fail_count),
    .pending       (pending),
    .events_seen   (events_seen)
  );

  // Mostly no idling, sometimes a few cycles, rarely a long stretch
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Enter at any time; return right after the accepting edge
  task automatic send_item(input logic [MODE_W-1:0] mode, input logic [NOTE_W-1:0] note,
                           input logic [VEL_W-1:0] vel, input logic [STEP_W-1:0] idx,
                           input logic act);
    int gap;
    gap = gaps_on ? idle_len() : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {5'b0, act, idx, vel, note};
    do @(posedge clk_i); while (!s_axis_tready);
    if (mode <= MODE_RECORD) accepted_items++;
  endtask

  task automatic send_random(input logic [MODE_W-1:0] mode);
    send_item(mode, NOTE_W'($urandom), VEL_W'($urandom), STEP_W'($urandom), 1'($urandom));
  endtask

  // Hold off until every due event is out and the back end has gone quiet
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_pattern_timing(input logic [CNT_W-1:0] ticks,
                                    input logic [STEP_W-1:0] first,
                                    input logic [STEP_W-1:0] last);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_STEP_PERIOD;
    cfg_data_i <= ticks;
    @(negedge clk_i);
    cfg_idx_i  <= REG_FIRST_STEP;
    cfg_data_i <= CFG_DATA_W'(first);
    @(negedge clk_i);
    cfg_idx_i  <= REG_LAST_STEP;
    cfg_data_i <= CFG_DATA_W'(last);
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    timing_settings++;
  endtask

  task automatic random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 58) begin
      send_random(MODE_TICK);
    end else if (pick < 68) begin
      send_random(MODE_NOTE);
    end else if (pick < 80) begin
      send_random(MODE_EDIT);
    end else if (pick < 87) begin
      send_random(MODE_TOGGLE);
    end else if (pick < 95) begin
      // record take: a few real notes, then often resume playback
      send_random(MODE_RECORD);
      repeat ($urandom_range(2, 6)) begin
        send_item(MODE_NOTE, NOTE_W'($urandom), VEL_W'($urandom_range(1, 127)),
                  STEP_W'($urandom), 1'($urandom));
      end
      if ($urandom_range(0, 1) == 1) send_random(MODE_TOGGLE);
    end else begin
      send_random(MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI)));
    end
  endtask

  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      int busy;
      int stall;
      busy = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 8);
      m_axis_tready <= 1'b1;
      repeat (busy) @(negedge clk_i);
      stall = idle_len();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
    end
  end

  initial begin : stimulus
    logic [CNT_W-1:0]  ticks;
    logic [STEP_W-1:0] first;
    logic [STEP_W-1:0] last;
    int                count;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = MODE_TICK;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_STEP_PERIOD;
    cfg_data_i    = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // short period of two ticks: note-on and note-off within a few ticks
    set_pattern_timing(26'd2, 4'd0, 4'd15);
    repeat (6) send_random(MODE_TICK);
    send_item(MODE_EDIT, 7'd127, 7'd127, 4'd15, 1'b1);
    send_item(MODE_EDIT, 7'd0, 7'd0, 4'd0, 1'b0);
    send_item(MODE_EDIT, 7'h55, 7'h2A, 4'd5, 1'b1);
    repeat (2) send_random(MODE_TICK);
    send_item(MODE_SPARE_LO, 7'd127, 7'd127, 4'd15, 1'b1);
    send_item(MODE_SPARE_HI, 7'd0, 7'd0, 4'd0, 1'b0);
    // a note while not recording is dropped
    send_item(MODE_NOTE, 7'd60, 7'd100, 4'd3, 1'b0);
    send_random(MODE_TOGGLE);
    send_random(MODE_TICK);
    send_random(MODE_TOGGLE);
    send_random(MODE_RECORD);
    send_item(MODE_NOTE, 7'd64, 7'd0, 4'd0, 1'b0);
    send_item(MODE_NOTE, 7'd127, 7'd127, 4'd15, 1'b1);
    send_item(MODE_NOTE, 7'd0, 7'd1, 4'd0, 1'b0);
    send_random(MODE_TOGGLE);
    // zero period with a two-step loop: a step on every tick, wrapping fast
    set_pattern_timing(26'd0, 4'd1, 4'd2);
    repeat (6) send_random(MODE_TICK);

    for (int p = 0; p < 8; p++) begin
      case (p)
        0:       ticks = 26'd3;
        1:       ticks = 26'd60000000;
        2:       ticks = 26'h3FFFFFF;
        3:       ticks = 26'd1;
        default: ticks = CNT_W'($urandom_range(2, 12));
      endcase
      first = (p % 3 == 0) ? 4'd0 : (p % 3 == 1) ? 4'd15 : STEP_W'($urandom_range(0, 15));
      last  = (p % 4 == 0) ? 4'd15 : (p % 4 == 1) ? 4'd0 : STEP_W'($urandom_range(0, 15));
      set_pattern_timing(ticks, first, last);
      gaps_on = ($urandom_range(0, 3) != 0);
      // long periods never play a step, so keep those phases short
      count = (ticks > 26'd1000) ? 12 : 32;
      repeat (count) random_item();
    end

    drain();
    $display("Covered %0d items over %0d step timing settings; %0d note events compared",
             accepted_items, timing_settings, events_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #1_500_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
